### sv/mexp_pkg.sv
// Shared types for the modular exponentiation block: request and response
// payloads, controller states, and the command/status bundles.
// No dependencies.
`default_nettype none

package mexp_pkg;

    localparam int FIELD_W = 32;

    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
    } mexp_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] power_mod;
        logic               bad_modulus;
    } mexp_resp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_REDUCE,
        ST_STEP,
        ST_MUL_ACC,
        ST_MUL_SQ,
        ST_WRITE
    } mexp_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // capture the request operands
        logic mul_start;   // launch the modular multiplier
        logic mul_square;  // multiplier operand a comes from the square register
        logic write_acc;   // store the product into the accumulator
        logic write_sq;    // store the product into the square register
        logic shift_exp;   // move to the next exponent bit
        logic load_out;    // capture the result into the output register
    } mexp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic mod_zero;    // incoming request has a zero modulus
        logic exp_zero;    // incoming request has a zero exponent
        logic exp_bit0;    // current exponent bit
        logic exp_last;    // no set bits remain above the current one
        logic mul_done;    // multiplier finished this cycle
    } mexp_status_t;

endpackage

`default_nettype wire

### sv/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: p = a * b mod n, one bit of b
// per cycle, most significant first. Requires a < n. Uses mexp_pkg.
`default_nettype none

module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic [WIDTH-1:0] n,
    output logic      [WIDTH-1:0] p,
    output logic                  done
);

    localparam int CW = $clog2(WIDTH + 1);
    localparam logic [CW-1:0] CNT_INIT = CW'(WIDTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic [WIDTH-1:0] a_reg, b_reg, p_reg;
    logic [WIDTH-1:0] a_next, b_next, p_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] n1;
    logic [WIDTH+1:0] n2;
    logic [WIDTH+1:0] red;

    // sum = 2*p + bit*a stays below 3n, so subtracting n or 2n at most once
    // brings it back into range.
    always_comb
    begin
        n1  = {2'b00, n};
        n2  = {1'b0, n, 1'b0};
        sum = {1'b0, p_reg, 1'b0} + (b_reg[WIDTH-1] ? {2'b00, a_reg} : '0);
        if (sum >= n2)
        begin
            red = sum - n2;
        end
        else if (sum >= n1)
        begin
            red = sum - n1;
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            p_next    = '0;
            cnt_next  = CNT_INIT;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            p_next   = red[WIDTH-1:0];
            b_next   = {b_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_ONE;
            if (cnt_reg == CNT_ONE)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign p    = p_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### sv/mexp_datapath.sv
// Datapath of the modular exponentiation block: operand, accumulator,
// square and output registers around one serial modular multiplier.
// Uses mexp_pkg and mexp_mulmod.
`default_nettype none

module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire mexp_req_t    req,
    input  wire mexp_cmd_t    cmd,
    output mexp_status_t      status,
    output mexp_resp_t        resp
);

    localparam logic [WIDTH-1:0] ONE_W = WIDTH'(1);

    logic [WIDTH-1:0] base_w, exp_w, mod_w;
    logic [WIDTH-1:0] one_mod;
    logic             mod_zero, exp_zero;

    logic [WIDTH-1:0] mod_reg, exp_reg, acc_reg, sq_reg;
    logic [WIDTH-1:0] mod_next, exp_next, acc_next, sq_next;
    logic             bad_reg, bad_next;
    mexp_resp_t       resp_reg, resp_next;

    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_p;
    logic             mul_done;

    assign base_w   = WIDTH'(req.base);
    assign exp_w    = WIDTH'(req.exponent);
    assign mod_w    = WIDTH'(req.modulus);
    assign mod_zero = (mod_w == '0);
    assign exp_zero = (exp_w == '0);
    // One reduced by the modulus: zero only for a modulus of one.
    assign one_mod  = (mod_w == ONE_W) ? '0 : ONE_W;

    assign mul_a = cmd.mul_square ? sq_reg : acc_reg;

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (sq_reg),
        .n     (mod_reg),
        .p     (mul_p),
        .done  (mul_done)
    );

    always_comb
    begin
        mod_next  = mod_reg;
        exp_next  = exp_reg;
        acc_next  = acc_reg;
        sq_next   = sq_reg;
        bad_next  = bad_reg;
        resp_next = resp_reg;
        if (cmd.load)
        begin
            mod_next = mod_w;
            exp_next = exp_w;
            // The base is reduced by the multiplier as one_mod * base.
            sq_next  = base_w;
            bad_next = mod_zero;
            if (mod_zero)
            begin
                acc_next = '0;
            end
            else if (exp_zero)
            begin
                acc_next = ONE_W;
            end
            else
            begin
                acc_next = one_mod;
            end
        end
        else
        begin
            if (cmd.write_acc)
            begin
                acc_next = mul_p;
            end
            if (cmd.write_sq)
            begin
                sq_next = mul_p;
            end
            if (cmd.shift_exp)
            begin
                exp_next = exp_reg >> 1;
            end
        end
        if (cmd.load_out)
        begin
            resp_next.power_mod   = FIELD_W'(acc_reg);
            resp_next.bad_modulus = bad_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg  <= mod_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        bad_reg  <= bad_next;
        resp_reg <= resp_next;
    end

    always_comb
    begin
        status.mod_zero = mod_zero;
        status.exp_zero = exp_zero;
        status.exp_bit0 = exp_reg[0];
        status.exp_last = (exp_reg[WIDTH-1:1] == '0);
        status.mul_done = mul_done;
    end

    assign resp = resp_reg;

endmodule

`default_nettype wire

### sv/mexp_ctrl.sv
// Controller of the modular exponentiation block: sequences base reduction
// and the square-and-multiply steps, and owns both handshakes.
// Uses mexp_pkg.
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_stall,
    output logic              resp_valid,
    input  wire logic         resp_stall,
    input  wire mexp_status_t status,
    output mexp_cmd_t         cmd
);

    mexp_state_t state_reg, state_next;
    logic        resp_valid_reg, resp_valid_next;
    logic        out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !resp_valid_reg || !resp_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.mod_zero || status.exp_zero)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (status.mul_done)
                begin
                    cmd.write_sq = 1'b1;
                    state_next   = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (status.exp_bit0)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL_ACC;
                end
                else if (status.exp_last)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    cmd.mul_start  = 1'b1;
                    cmd.mul_square = 1'b1;
                    state_next     = ST_MUL_SQ;
                end
            end
            ST_MUL_ACC:
            begin
                if (status.mul_done)
                begin
                    cmd.write_acc = 1'b1;
                    if (status.exp_last)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        // The square only reads the square register, so it can
                        // start while the accumulator takes its new value.
                        cmd.mul_start  = 1'b1;
                        cmd.mul_square = 1'b1;
                        state_next     = ST_MUL_SQ;
                    end
                end
            end
            ST_MUL_SQ:
            begin
                if (status.mul_done)
                begin
                    cmd.write_sq  = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = ST_STEP;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            resp_valid_next = 1'b1;
        end
        else if (!resp_stall)
        begin
            resp_valid_next = 1'b0;
        end
        else
        begin
            resp_valid_next = resp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    assign resp_valid = resp_valid_reg;

endmodule

`default_nettype wire

### sv/modular_exponentiation_top.sv
// Modular exponentiation, base ** exponent mod modulus, by right-to-left
// square-and-multiply over WIDTH-bit operands (each 32-bit request field is
// cut or zero-extended to WIDTH bits). One request is worked at a time. Every
// modular multiply goes through a single bit-serial multiplier. A request
// first reduces its base with one multiply, then passes through one step
// state per exponent bit up to the top set bit, with a multiply for each set
// bit, a square per bit below it. The next request can be accepted only once
// the response has been written into the output register. A zero modulus
// returns 0 with bad_modulus set, and a zero exponent returns 1; either
// request skips the multiplier and goes straight to the write state. The
// output register holds a finished response while the next request is
// accepted and computed; a result that finds it still stalled waits until it
// drains.
// Uses mexp_pkg, mexp_ctrl and mexp_datapath.
`default_nettype none

module modular_exponentiation_top
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire mexp_req_t  req,
    output logic            resp_valid,
    input  wire logic       resp_stall,
    output mexp_resp_t      resp
);

    mexp_cmd_t    cmd;
    mexp_status_t status;

    mexp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .status     (status),
        .cmd        (cmd)
    );

    mexp_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .resp   (resp)
    );

endmodule

`default_nettype wire

### sv/mexp_checker.sv
// Port-level checks for the modular exponentiation block, and the bind that
// attaches them to modular_exponentiation_top. Uses mexp_pkg.
`default_nettype none

module mexp_checker
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      req_valid,
    input wire logic      req_stall,
    input wire mexp_req_t req,
    input wire logic      resp_valid,
    input wire logic      resp_stall,
    input wire mexp_resp_t resp
);

    // A flagged modulus always comes with a zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp.bad_modulus |-> resp.power_mod == '0)
    else $error("bad_modulus response with nonzero power_mod");

    // Only one request is in work, so the block stalls right after accepting.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("request accepted while another is in work");

    // A zero modulus with the output empty is answered via the write state.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !resp_valid && (WIDTH'(req.modulus) == '0)
        |=> ##1 resp_valid && resp.bad_modulus)
    else $error("zero modulus not flagged on time");

    // A stalled response holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp_stall |=> resp_valid && $stable(resp))
    else $error("stalled response changed");

endmodule

bind modular_exponentiation_top mexp_checker #(
    .WIDTH (WIDTH)
) u_mexp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp)
);

`default_nettype wire
